// ===== sv/assert_macros.svh =====
// Assertion helpers for the tagged identifier parser.
// Each macro has a checking form and an empty form for synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define CHK_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CHK_ALWAYS(lbl, clk, rstn, expr)
`define CHK_IMPLY(lbl, clk, rstn, ante, cons)
`define CHK_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/tip_pkg.sv =====
package tip_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    // Parser phase, one-hot.
    typedef enum logic [1:0] {
        PH_LETTER = 2'b01,
        PH_DIGIT  = 2'b10
    } phase_t;

    // Register indexes on the configuration port (word address).
    localparam logic REG_TAG_CHECK_ON = 1'b0;
    localparam logic REG_EXPECTED_TAG = 1'b1;

    localparam int TAG_W  = 15;
    localparam int CODE_W = 5;
    localparam int ID_W   = 63;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_Z = 8'h7a;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    // Subtracting this from a lower-case letter gives a=1 .. z=26.
    localparam logic [7:0] CHAR_CODE_BASE = 8'h60;

endpackage

// ===== sv/tagged_id_text_parser_top.sv =====
// A terminating zero byte passes through the input register and then the result register, which drives m_valid.
// Throughput: one character byte per cycle, sustained, provided the result side takes results.
// A terminator waits in the input register while an earlier result is still unaccepted.
// The clock period is set by the combinational multiply-by-ten, add and overflow compare on the number.
// Reset: aresetn is synchronous and active low; it clears the parser state, both pipeline
// valid flags and the two configuration registers (tag checking off, expected tag zero).
`include "assert_macros.svh"

module tagged_id_text_parser_top #(
    parameter int NUM_BITS = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Character input channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_byte,

    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output tip_pkg::status_t      m_status,
    output logic [62:0]           m_id_value,
    output logic [14:0]           m_parsed_tag,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    import tip_pkg::*;

    // The number accumulator is widened by four bits so that ten times it plus a digit
    // always fits, and overflow shows up as any of those top bits being set.
    localparam int WIDE_W = NUM_BITS + 4;

    // ------------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase; the
    // register is chosen by the word address, so byte offsets within a word are
    // ignored.
    // ------------------------------------------------------------------------
    logic             tag_check_on_reg;
    logic [TAG_W-1:0] expected_tag_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_check_on_reg <= 1'b0;
            expected_tag_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_TAG_CHECK_ON: tag_check_on_reg <= pwdata[0];
                REG_EXPECTED_TAG: expected_tag_reg <= pwdata[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TAG_CHECK_ON: prdata = 32'(tag_check_on_reg);
            REG_EXPECTED_TAG: prdata = 32'(expected_tag_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Input register. Each accepted transaction lands here and is consumed by the
    // parsing stage once it can advance. Only a terminator needs room in the
    // result register, so ordinary characters never stall.
    // ------------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       is_term;
    logic       advance;

    assign is_term = (in_byte_reg == CHAR_NUL);
    assign advance = in_valid_reg && (!is_term || !m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_char_byte;
        end
    end

    // ------------------------------------------------------------------------
    // Parser state and its next value for the byte in the input register.
    // ------------------------------------------------------------------------
    phase_t              phase_reg,   phase_next;
    logic [1:0]          count_reg,   count_next;
    logic [TAG_W-1:0]    tag_reg,     tag_next;
    logic [NUM_BITS-1:0] num_reg,     num_next;
    logic                error_reg,   error_next;

    logic              is_lower;
    logic              is_digit;
    logic              is_nonzero_digit;
    logic [CODE_W-1:0] letter_code;
    logic [3:0]        digit_val;
    logic [WIDE_W-1:0] num_wide;
    logic              overflow;

    assign is_lower         = (in_byte_reg >= CHAR_LO_A) && (in_byte_reg <= CHAR_LO_Z);
    assign is_digit         = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign is_nonzero_digit = (in_byte_reg >= CHAR_ONE)  && (in_byte_reg <= CHAR_NINE);
    assign letter_code      = CODE_W'(in_byte_reg - CHAR_CODE_BASE);
    assign digit_val        = 4'(in_byte_reg - CHAR_ZERO);

    // Ten times the number is eight times plus two times, then the new digit.
    assign num_wide = {1'b0, num_reg, 3'b000}
                    + {3'b000, num_reg, 1'b0}
                    + WIDE_W'(digit_val);
    assign overflow = (num_wide[WIDE_W-1:NUM_BITS] != '0);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        tag_next   = tag_reg;
        num_next   = num_reg;
        error_next = error_reg;

        if (is_term) begin
            // The result is taken from the current state; the parser starts afresh.
            phase_next = PH_LETTER;
            count_next = '0;
            tag_next   = '0;
            num_next   = '0;
            error_next = 1'b0;
        end else if (!error_reg) begin
            unique case (phase_reg)
                PH_LETTER: begin
                    if (is_lower && count_reg != 2'd3) begin
                        case (count_reg)
                            2'd0:    tag_next[14:10] = letter_code;
                            2'd1:    tag_next[9:5]   = letter_code;
                            default: tag_next[4:0]   = letter_code;
                        endcase
                        count_next = count_reg + 2'd1;
                    end else if (count_reg != '0 && is_nonzero_digit) begin
                        phase_next = PH_DIGIT;
                        num_next   = NUM_BITS'(digit_val);
                    end else begin
                        error_next = 1'b1;
                    end
                end
                PH_DIGIT: begin
                    if (is_digit && !overflow) begin
                        num_next = num_wide[NUM_BITS-1:0];
                    end else begin
                        error_next = 1'b1;
                    end
                end
                default: error_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LETTER;
            count_reg <= '0;
            tag_reg   <= '0;
            num_reg   <= '0;
            error_reg <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
            num_reg   <= num_next;
            error_reg <= error_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result formation and the result register. A syntax error wipes both the
    // identifier and the tag; a mismatch reports the tag only.
    // ------------------------------------------------------------------------
    status_t          res_status;
    logic [ID_W-1:0]  res_id;
    logic [TAG_W-1:0] res_tag;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic [TAG_W-1:0] out_tag_reg;

    always_comb begin
        res_status = ST_OK;
        res_id     = '0;
        res_tag    = '0;
        if (error_reg || phase_reg != PH_DIGIT) begin
            res_status = ST_SYNTAX;
        end else if (tag_check_on_reg && tag_reg != expected_tag_reg) begin
            res_status = ST_MISMATCH;
            res_tag    = tag_reg;
        end else begin
            res_tag = tag_reg;
            res_id  = ID_W'({tag_reg, num_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_term) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_term) begin
            out_status_reg <= res_status;
            out_id_reg     <= res_id;
            out_tag_reg    <= res_tag;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_id_value   = out_id_reg;
    assign m_parsed_tag = out_tag_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `CHK_IMPLY(a_digit_needs_letter, aclk, aresetn, phase_reg == PH_DIGIT, count_reg != 2'd0)
    `CHK_NEXT(a_clear_after_term, aclk, aresetn, advance && is_term,
              phase_reg == PH_LETTER && count_reg == 2'd0 && !error_reg && num_reg == '0)
    `CHK_NEXT(a_error_sticky, aclk, aresetn, error_reg && !(advance && is_term), error_reg)
    `CHK_IMPLY(a_ok_id_carries_tag, aclk, aresetn, m_valid && m_status == ST_OK,
               m_id_value[NUM_BITS +: TAG_W] == m_parsed_tag)

endmodule

// ===== test/tagged_id_text_parser_top_tb.sv =====
`timescale 1ns / 100ps

module tagged_id_text_parser_top_tb;

    import tip_pkg::*;

    localparam int NUM_BITS = 48;
    localparam logic [NUM_BITS-1:0] NUM_MAX = '1;
    // A terminator's result passes the input and result registers; allow a margin.
    localparam int SETTLE_CYCLES  = 8;
    // The long receiver hold-off must stay well inside the watchdog limit.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES_PER_PHASE = 400;

    // One result as the parser is expected to report it.
    typedef struct {
        status_t          status;
        logic [ID_W-1:0]  id_value;
        logic [TAG_W-1:0] parsed_tag;
    } id_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_char_byte = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    status_t m_status;
    logic [ID_W-1:0] m_id_value;
    logic [TAG_W-1:0] m_parsed_tag;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Results still owed by the parser, oldest first.
    id_result_t id_results_due[$];
    int fail_count = 0;

    // Our own copy of the parser state and of the two configuration registers.
    bit in_digits = 1'b0;
    int letters_taken = 0;
    logic [TAG_W-1:0] tag_so_far = '0;
    logic [NUM_BITS-1:0] number_so_far = '0;
    bit syntax_fault = 1'b0;
    bit cfg_tag_check = 1'b0;
    logic [TAG_W-1:0] cfg_expected_tag = '0;

    // Traffic shaping: percentages of cycles in which each side holds back.
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    // Bumping the token asks the receiver process for one long hold-off.
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    tagged_id_text_parser_top #(
        .NUM_BITS(NUM_BITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_id_value  (m_id_value),
        .m_parsed_tag(m_parsed_tag),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 aclk = ~aclk;

    // Advances the parser copy by one accepted character. A zero byte closes the
    // identifier, queues the single result it owes and clears the state again.
    function automatic void parse_char(input logic [7:0] c);
        id_result_t due;
        logic [NUM_BITS+3:0] grown;
        int shift;
        if (c == CHAR_NUL) begin
            if (syntax_fault || !in_digits)
                due = '{ST_SYNTAX, '0, '0};
            else if (cfg_tag_check && tag_so_far != cfg_expected_tag)
                due = '{ST_MISMATCH, '0, tag_so_far};
            else
                due = '{ST_OK, {tag_so_far, number_so_far}, tag_so_far};
            id_results_due.push_back(due);
            in_digits = 1'b0;
            letters_taken = 0;
            tag_so_far = '0;
            number_so_far = '0;
            syntax_fault = 1'b0;
        end else if (!syntax_fault) begin
            if (!in_digits) begin
                if (c >= CHAR_LO_A && c <= CHAR_LO_Z && letters_taken < 3) begin
                    // First letter lands in the top five bits of the tag.
                    shift = 10 - 5 * letters_taken;
                    tag_so_far |= TAG_W'(c - CHAR_CODE_BASE) << shift;
                    letters_taken++;
                end else if (letters_taken != 0 && c >= CHAR_ONE && c <= CHAR_NINE) begin
                    in_digits = 1'b1;
                    number_so_far = NUM_BITS'(c - CHAR_ZERO);
                end else begin
                    syntax_fault = 1'b1;
                end
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                grown = (NUM_BITS+4)'(number_so_far) * 10 + (NUM_BITS+4)'(c - CHAR_ZERO);
                if (grown > (NUM_BITS+4)'(NUM_MAX))
                    syntax_fault = 1'b1;
                else
                    number_so_far = grown[NUM_BITS-1:0];
            end else begin
                syntax_fault = 1'b1;
            end
        end
    endfunction

    function automatic logic [TAG_W-1:0] pack_tag(input string letters);
        logic [TAG_W-1:0] t;
        t = '0;
        foreach (letters[i])
            t |= TAG_W'(8'(letters[i]) - CHAR_CODE_BASE) << (10 - 5 * i);
        return t;
    endfunction

    // Builds one random identifier, without its terminator. Most are well formed,
    // some are damaged in one place and a few are plain noise.
    function automatic void build_identifier(input string favoured, output logic [7:0] text[$]);
        int kind;
        int n_letters;
        int pos;
        longint unsigned num;
        string digits;
        text = {};
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(6)) text.push_back(8'($urandom_range(255, 1)));
            return;
        end
        if (favoured.len() != 0 && $urandom_range(1) == 1) begin
            foreach (favoured[i]) text.push_back(8'(favoured[i]));
        end else begin
            repeat ($urandom_range(3, 1)) text.push_back(CHAR_LO_A + 8'($urandom_range(25)));
        end
        n_letters = text.size();
        case ($urandom_range(3))
            0: num = $urandom_range(9, 1);
            1: num = $urandom();
            // Straddle the largest number that still fits.
            2: num = longint'(NUM_MAX) - 10 + $urandom_range(20);
            default: num = {$urandom(), $urandom()} >> $urandom_range(16);
        endcase
        digits = $sformatf("%0d", num);
        foreach (digits[i]) text.push_back(8'(digits[i]));
        if (kind < 30) begin
            pos = $urandom_range(text.size());
            case ($urandom_range(4))
                0: text.insert(pos, 8'($urandom_range(255, 1)));
                1: text.insert(pos, CHAR_LO_A + 8'($urandom_range(25)));
                2: text.insert(n_letters, CHAR_ZERO);
                3: while (text.size() > n_letters) void'(text.pop_back());
                default: repeat (n_letters) text.delete(0);
            endcase
        end
    endfunction

    // Offers one character, holding it until the parser takes it.
    task automatic send_byte(input logic [7:0] c);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_byte <= c;
        do @(posedge aclk); while (!s_ready);
        parse_char(c);
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(8'(s[i]));
        send_byte(CHAR_NUL);
    endtask

    // Waits until every owed result has arrived and the pipeline has drained.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (id_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register, then checks that reading it back gives the new value.
    task automatic write_register(input logic index, input logic [31:0] value);
        logic [31:0] expect_rd;
        wait_until_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_TAG_CHECK_ON: cfg_tag_check = value[0];
            REG_EXPECTED_TAG: cfg_expected_tag = value[TAG_W-1:0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        expect_rd = (index == REG_TAG_CHECK_ON) ? 32'(value[0]) : 32'(value[TAG_W-1:0]);
        if (prdata !== expect_rd) begin
            $error("field prdata: expected %0h, actual %0h", expect_rd, prdata);
            fail_count++;
        end
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    task automatic send_random_identifiers(input int n_bytes, input string favoured);
        logic [7:0] text[$];
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_identifier(favoured, text);
            foreach (text[i]) send_byte(text[i]);
            send_byte(CHAR_NUL);
            sent += text.size() + 1;
        end
    endtask

    // Shortest cases and each kind of syntax fault but number overflow, with tag checking off.
    task automatic test_directed_cases();
        send_text("");          // empty string: no digit at all
        send_text("a1");        // smallest well-formed identifier
        send_text("zzz9");      // highest letter codes in every slot
        send_text("1");         // digit with no tag in front
        send_text("abcd1");     // a fourth letter
        send_text("a0");        // number opening with a zero
        send_text("a1x");       // letter after the digits
        send_byte(8'hFF);       // byte above the ASCII range
        send_byte(CHAR_NUL);
    endtask

    // The largest number accepted, and the first one past it.
    task automatic test_number_limits();
        send_text("a281474976710655");
        send_text("a281474976710656");
    endtask

    task automatic test_tag_check();
        write_register(REG_EXPECTED_TAG, 32'(pack_tag("abc")));
        write_register(REG_TAG_CHECK_ON, 32'd1);
        send_text("abc5");      // matching tag
        send_text("abd5");      // same length, different tag
        send_text("ab5");       // prefix of the expected tag
        send_text("abc0");      // a syntax fault wins over the tag check
        write_register(REG_EXPECTED_TAG, 32'h7FFF);
        send_text("zzz1");
    endtask

    // The receiver stops for a long stretch while short identifiers keep coming,
    // so the result side fills up and the parser has to refuse input.
    task automatic test_back_pressure();
        set_idling(0, 0);
        write_register(REG_TAG_CHECK_ON, 32'd0);
        hold_token <= hold_token + 1;
        repeat (40) send_text("a1");
    endtask

    // Random identifiers under each idling pattern and several register settings.
    task automatic test_random_traffic();
        set_idling(0, 0);
        write_register(REG_TAG_CHECK_ON, 32'd0);
        write_register(REG_EXPECTED_TAG, 32'd0);
        send_random_identifiers(RANDOM_BYTES_PER_PHASE, "");

        set_idling(48, 0);
        write_register(REG_EXPECTED_TAG, 32'(pack_tag("q")));
        write_register(REG_TAG_CHECK_ON, 32'd1);
        send_random_identifiers(RANDOM_BYTES_PER_PHASE, "q");

        set_idling(0, 48);
        write_register(REG_EXPECTED_TAG, 32'(pack_tag("kew")));
        send_random_identifiers(RANDOM_BYTES_PER_PHASE, "kew");

        set_idling(8, 8);
        write_register(REG_EXPECTED_TAG, 32'h7FFF);
        send_random_identifiers(RANDOM_BYTES_PER_PHASE, "zzz");
    endtask

    initial begin : run_tests
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_number_limits();
        test_tag_check();
        test_back_pressure();
        test_random_traffic();
        wait_until_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // The receiver takes results at random, apart from the requested hold-off,
    // whose length it counts itself.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Every result transaction is matched against the oldest owed result.
    always @(posedge aclk) begin : result_check
        id_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (id_results_due.size() == 0) begin
                $error("result with none owed: status %0d, id_value %0h, parsed_tag %0h",
                       m_status, m_id_value, m_parsed_tag);
                fail_count++;
            end else begin
                due = id_results_due.pop_front();
                if (m_status !== due.status) begin
                    $error("field status: expected %0d, actual %0d", due.status, m_status);
                    fail_count++;
                end
                if (m_id_value !== due.id_value) begin
                    $error("field id_value: expected %0h, actual %0h", due.id_value, m_id_value);
                    fail_count++;
                end
                if (m_parsed_tag !== due.parsed_tag) begin
                    $error("field parsed_tag: expected %0h, actual %0h",
                           due.parsed_tag, m_parsed_tag);
                    fail_count++;
                end
            end
        end
    end

    // The run is stopped when no transaction of any kind has happened for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
